>>> src/tfr_pkg.sv
// ----------------------------------------------------------------------------
// Telemetry frame receiver package
// Byte codes, frame lengths, parser state and the words passed between the
// front parser and the back assembler.
// ----------------------------------------------------------------------------
package tfr_pkg;

  localparam logic [7:0] HdrByte   = 8'h55;
  localparam logic [7:0] CodeShort = 8'hF1;
  localparam logic [7:0] CodeLong  = 8'hF2;
  localparam logic [7:0] TailByte  = 8'hAA;

  localparam int unsigned ShortLen     = 7;
  localparam int unsigned LongLen      = 15;
  localparam int unsigned PayloadDepth = 12;
  localparam int unsigned PosW         = 4;

  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhCode = 2'd1,
    PhData = 2'd2
  } phase_e;

  typedef struct packed {
    logic            is_tail;
    logic            long_frame;
    logic            tail_ok;
    logic [PosW-1:0] pos;
    logic [7:0]      data;
  } evt_t;

  typedef struct packed {
    logic        frame_kind;
    logic        tail_ok;
    logic [15:0] left_hall_speed;
    logic [15:0] right_hall_speed;
    logic [31:0] first_position_word;
    logic [31:0] second_position_word;
  } res_t;

endpackage

>>> src/tfr_front.sv
// ----------------------------------------------------------------------------
// Telemetry frame receiver front parser
// Tracks header, function code and byte position; payload bytes become store
// words and a frame's last byte becomes a tail word for the back part.
// ----------------------------------------------------------------------------
module tfr_front import tfr_pkg::*; #(
  parameter int unsigned RX_BUFFER_BYTES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic       full_i,
  input  logic [7:0] rx_byte_i,
  output logic       evt_valid_o,
  output evt_t       evt_o
);

  localparam int unsigned IdxW = $clog2(RX_BUFFER_BYTES + 1);

  phase_e          phase_q, phase_d;
  logic            long_q, long_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] idx_inc;
  logic [IdxW-1:0] idx_off;
  logic [IdxW-1:0] frame_len;
  logic            accept;

  assign accept    = push_i & ~full_i;
  assign idx_inc   = idx_q + IdxW'(1);
  assign idx_off   = idx_q - IdxW'(2);
  assign frame_len = long_q ? IdxW'(LongLen) : IdxW'(ShortLen);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      long_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      phase_q <= phase_d;
      long_q  <= long_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    phase_d           = phase_q;
    long_d            = long_q;
    idx_d             = idx_q;
    evt_valid_o       = 1'b0;
    evt_o.is_tail     = 1'b0;
    evt_o.long_frame  = long_q;
    evt_o.tail_ok     = (rx_byte_i == TailByte);
    evt_o.pos         = PosW'(idx_off);
    evt_o.data        = rx_byte_i;
    if (accept) begin
      if (rx_byte_i == HdrByte) begin
        phase_d = PhCode;
        idx_d   = IdxW'(1);
      end else begin
        unique case (phase_q)
          PhHunt: begin
          end
          PhCode: begin
            if (rx_byte_i == CodeShort || rx_byte_i == CodeLong) begin
              long_d  = (rx_byte_i == CodeLong);
              idx_d   = IdxW'(2);
              phase_d = PhData;
            end
          end
          PhData: begin
            priority if (idx_q >= IdxW'(RX_BUFFER_BYTES)) begin
              phase_d = PhHunt;
              idx_d   = '0;
            end else if (idx_inc < frame_len) begin
              if (idx_q >= IdxW'(2) && idx_off < IdxW'(PayloadDepth)) begin
                evt_valid_o = 1'b1;
              end
              idx_d = idx_inc;
            end else begin
              evt_valid_o   = 1'b1;
              evt_o.is_tail = 1'b1;
              phase_d       = PhHunt;
              idx_d         = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

>>> src/tfr_evq.sv
// ----------------------------------------------------------------------------
// Telemetry frame receiver event queue
// Two-entry queue of parser words between the front and the back part.
// ----------------------------------------------------------------------------
module tfr_evq import tfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  evt_t evt_i,
  output logic full_o,
  output logic valid_o,
  output evt_t evt_o,
  input  logic pop_i
);

  evt_t       ent_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign evt_o   = ent_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= evt_i;
    end
  end

endmodule

>>> src/tfr_back.sv
// ----------------------------------------------------------------------------
// Telemetry frame receiver back assembler
// Stores payload bytes, builds the decoded frame on each tail word and holds
// finished frames in a two-entry result queue.
// ----------------------------------------------------------------------------
module tfr_back import tfr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic evt_valid_i,
  input  evt_t evt_i,
  output logic evt_pop_o,
  output logic empty_o,
  input  logic pop_i,
  output res_t res_o
);

  logic [7:0] payload_q [PayloadDepth];
  res_t       res_q [2];
  res_t       res_new;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] out_cnt_q;
  logic       res_push, res_pop;

  assign evt_pop_o = evt_valid_i & (~evt_i.is_tail | (out_cnt_q != 2'd2));
  assign res_push  = evt_pop_o & evt_i.is_tail;
  assign empty_o   = (out_cnt_q == 2'd0);
  assign res_pop   = pop_i & ~empty_o;
  assign res_o     = res_q[rd_ptr_q];

  always_comb begin
    res_new.frame_kind       = evt_i.long_frame;
    res_new.tail_ok          = evt_i.tail_ok;
    res_new.left_hall_speed  = {payload_q[1], payload_q[0]};
    res_new.right_hall_speed = {payload_q[3], payload_q[2]};
    if (evt_i.long_frame) begin
      res_new.first_position_word  = {payload_q[7], payload_q[6], payload_q[5], payload_q[4]};
      res_new.second_position_word = {payload_q[11], payload_q[10], payload_q[9], payload_q[8]};
    end else begin
      res_new.first_position_word  = '0;
      res_new.second_position_word = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (evt_pop_o && !evt_i.is_tail) begin
      payload_q[evt_i.pos] <= evt_i.data;
    end
    if (res_push) begin
      res_q[wr_ptr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q  <= 1'b0;
      rd_ptr_q  <= 1'b0;
      out_cnt_q <= 2'd0;
    end else begin
      if (res_push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (res_pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      out_cnt_q <= out_cnt_q + {1'b0, res_push} - {1'b0, res_pop};
    end
  end

`ifndef SYNTHESIS
  a_out_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_cnt_q <= 2'd2)
    else $error("Result queue count out of range.");

  a_stall_only_on_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && !evt_pop_o |-> evt_i.is_tail && out_cnt_q == 2'd2)
    else $error("Back part stalled without a full result queue.");

  a_tail_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_pop_o && evt_i.is_tail |=> !empty_o)
    else $error("Taken tail word left no result.");

  a_short_zero_words: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !res_o.frame_kind |->
      res_o.first_position_word == '0 && res_o.second_position_word == '0)
    else $error("Short frame carries position words.");
`endif

endmodule

>>> src/telemetry_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// Telemetry frame receiver
// Assembles header, function code and payload bytes into decoded frames.
// ----------------------------------------------------------------------------
// Usage: bytes from the serial link enter on rx_byte_i through a queue-style
// port: a word is taken at a clock edge where push is high and full is low.
// Decoded frames leave through a queue-style port: while empty is low the
// oldest frame is on the result ports, and it is taken when pop is high.
// The block takes one byte every cycle while full is low. Full rises only
// after the result queue of two frames has filled and the two-entry queue
// between the parser and the assembler holds a waiting tail byte and one
// more word. A frame enters the result queue when the assembler takes its
// tail word, and one whose tail byte is not 0xAA is still delivered, with
// tail_ok_o low. Position words are zero for short frames. Reset puts the
// parser in header search and empties both queues; stored payload bytes are
// not cleared, and every frame writes the bytes that it reads before its
// tail arrives. When the receiver holds pop low, finished frames stay queued
// and the byte side keeps running until the queues are full.
// ----------------------------------------------------------------------------
module telemetry_frame_receiver_top import tfr_pkg::*; #(
  parameter int unsigned RX_BUFFER_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        frame_kind_o,
  output logic        tail_ok_o,
  output logic [15:0] left_hall_speed_o,
  output logic [15:0] right_hall_speed_o,
  output logic [31:0] first_position_word_o,
  output logic [31:0] second_position_word_o
);

  logic evt_push;
  evt_t evt_in;
  logic evt_valid;
  evt_t evt_out;
  logic evt_pop;
  res_t res;

  tfr_front #(
    .RX_BUFFER_BYTES(RX_BUFFER_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .full_i     (full),
    .rx_byte_i  (rx_byte_i),
    .evt_valid_o(evt_push),
    .evt_o      (evt_in)
  );

  tfr_evq u_evq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (evt_push),
    .evt_i  (evt_in),
    .full_o (full),
    .valid_o(evt_valid),
    .evt_o  (evt_out),
    .pop_i  (evt_pop)
  );

  tfr_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_valid_i(evt_valid),
    .evt_i      (evt_out),
    .evt_pop_o  (evt_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .res_o      (res)
  );

  assign frame_kind_o           = res.frame_kind;
  assign tail_ok_o              = res.tail_ok;
  assign left_hall_speed_o      = res.left_hall_speed;
  assign right_hall_speed_o     = res.right_hall_speed;
  assign first_position_word_o  = res.first_position_word;
  assign second_position_word_o = res.second_position_word;

endmodule
